/* rtl/uwrc_pkg.sv */
// ---------------------------------------------------------------------------
// uwrc_pkg: shared types and constants of the waypoint rollout controller
// Fixed-point constants, the arctangent table, angle wrapping, rounding and
// the sequencer control and status structs.
// ---------------------------------------------------------------------------
package uwrc_pkg;

  // Angle constants, Q3.16 and Q2.30.
  localparam int PI_Q16     = 205887;
  localparam int TWO_PI_Q16 = 411775;
  localparam logic signed [33:0] PI_Q30      = 34'sd3373259426;
  localparam logic signed [33:0] HALF_PI_Q30 = 34'sd1686629713;

  // CORDIC datapath widths and constants.
  localparam int XY_W       = 48;
  localparam int Z_W        = 34;
  localparam int ANG_W      = 20;
  localparam int MAG_W      = 35;
  localparam int TRIG_W     = 34;
  localparam int ATAN_IDX_W = 5;
  localparam logic signed [XY_W-1:0] ROT_START_Q30 = 48'sd652032874;
  localparam logic [17:0] MAG_GAIN_Q18 = 18'd159188;

  // Control law constants.
  localparam int TURN_MAX  = 52429;
  localparam int BIAS_MAX  = 26214;
  localparam int ERR_LIMIT = 19660;
  localparam int SLOW_Q16  = 19661;
  localparam int FLOOR_Q17 = 26214;
  localparam int FAC_ONE   = 131072;
  localparam int REP_MIN   = 655;
  localparam int REP_SAT   = 104858;

  // Configuration register indexes.
  localparam logic REG_TIME_STEP   = 1'b0;
  localparam logic REG_SPEED_LIMIT = 1'b1;

  typedef enum logic {COR_VEC, COR_ROT} cor_mode_t;
  typedef enum logic {SRC_TGT, SRC_REP} cor_src_t;

  typedef enum logic [3:0] {
    ST_IDLE, ST_TGT_GO, ST_TGT_WAIT, ST_REP_GO, ST_REP_WAIT,
    ST_CTRL1, ST_CTRL2, ST_CTRL3, ST_ROT_GO, ST_ROT_WAIT, ST_INT, ST_OUT
  } state_t;

  typedef struct packed {
    logic      ready;
    logic      cor_start;
    cor_mode_t cor_mode;
    cor_src_t  cor_src;
    logic      cap_tgt;
    logic      cap_rep;
    logic      cap_rot;
    logic      ctrl1;
    logic      ctrl2;
    logic      ctrl3;
    logic      integ;
    logic      out_load;
  } seq_ctrl_t;

  typedef struct packed {
    logic in_valid;
    logic cor_done;
    logic out_free;
  } seq_stat_t;

  // Arctangent of 2^-i, Q2.30.
  function automatic logic signed [Z_W-1:0] atan_q30(input logic [ATAN_IDX_W-1:0] i);
    logic signed [Z_W-1:0] r;
    case (i)
      5'd0:  r = 34'sd843314857;
      5'd1:  r = 34'sd497837829;
      5'd2:  r = 34'sd263043837;
      5'd3:  r = 34'sd133525159;
      5'd4:  r = 34'sd67021687;
      5'd5:  r = 34'sd33543516;
      5'd6:  r = 34'sd16775851;
      5'd7:  r = 34'sd8388437;
      5'd8:  r = 34'sd4194283;
      5'd9:  r = 34'sd2097149;
      5'd10: r = 34'sd1048576;
      5'd11: r = 34'sd524288;
      5'd12: r = 34'sd262144;
      5'd13: r = 34'sd131072;
      5'd14: r = 34'sd65536;
      5'd15: r = 34'sd32768;
      5'd16: r = 34'sd16384;
      5'd17: r = 34'sd8192;
      5'd18: r = 34'sd4096;
      5'd19: r = 34'sd2048;
      5'd20: r = 34'sd1024;
      5'd21: r = 34'sd512;
      5'd22: r = 34'sd256;
      5'd23: r = 34'sd128;
      default: r = '0;
    endcase
    return r;
  endfunction

  // Bring an angle into [-pi, pi]; pi itself is kept.
  function automatic logic signed [23:0] wrap_pi(input logic signed [23:0] a);
    logic signed [23:0] r;
    r = a;
    for (int k = 0; k < 4; k++) begin
      if (r > PI_Q16) begin
        r = r - 24'(TWO_PI_Q16);
      end else if (r < -PI_Q16) begin
        r = r + 24'(TWO_PI_Q16);
      end
    end
    return r;
  endfunction

  // Arithmetic right shift with rounding half away from zero.
  function automatic logic signed [65:0] rnd_shift(input logic signed [65:0] v,
                                                   input int unsigned s);
    logic [65:0] m;
    logic [65:0] half;
    logic [65:0] r;
    half = 66'd1 << (s - 1);
    m = v[65] ? 66'(-v) : 66'(v);
    r = (m + half) >> s;
    return v[65] ? -$signed(r) : $signed(r);
  endfunction

endpackage

/* rtl/uwrc_cordic.sv */
// ---------------------------------------------------------------------------
// uwrc_cordic: shared iterative CORDIC unit
// Vectoring gives atan2 and the gain-corrected magnitude; rotation gives the
// cosine and sine of a heading. One micro-rotation per clock.
// ---------------------------------------------------------------------------
module uwrc_cordic
  import uwrc_pkg::*;
#(
  parameter int STEPS = 16
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     start,
  input  cor_mode_t                mode,
  input  logic signed [32:0]       vec_x,
  input  logic signed [32:0]       vec_y,
  input  logic signed [ANG_W-1:0]  rot_ang,
  output logic                     done,
  output logic signed [ANG_W-1:0]  res_ang,
  output logic [MAG_W-1:0]         res_mag,
  output logic signed [TRIG_W-1:0] res_cos,
  output logic signed [TRIG_W-1:0] res_sin
);

  localparam int CW = $clog2(STEPS);

  logic                   busy;
  logic                   fin;
  logic [CW-1:0]          cnt;
  logic signed [XY_W-1:0] x, y;
  logic signed [Z_W-1:0]  z;
  cor_mode_t              mode_r;
  logic                   neg;
  logic                   zero;

  logic signed [XY_W-1:0] vx, vy, ix, iy;
  logic signed [Z_W-1:0]  rz, iz;
  logic                   ineg;
  logic signed [XY_W-1:0] xs, ys, x_next, y_next;
  logic signed [Z_W-1:0]  a, z_next;
  logic                   cw;
  logic [XY_W-1:0]        xc;
  logic [65:0]            mprod;

  // Start vector: prescale and quadrant fold, or angle fold for rotation.
  always_comb begin
    vx = XY_W'(vec_x) <<< 12;
    vy = XY_W'(vec_y) <<< 12;
    rz = Z_W'(rot_ang) <<< 14;
    ineg = 1'b0;
    if (mode == COR_VEC) begin
      ix = vx;
      iy = vy;
      iz = '0;
      if (vx < 0) begin
        if (vy >= 0) begin
          ix = vy;
          iy = -vx;
          iz = HALF_PI_Q30;
        end else begin
          ix = -vy;
          iy = vx;
          iz = -HALF_PI_Q30;
        end
      end
    end else begin
      ix = ROT_START_Q30;
      iy = '0;
      iz = rz;
      if (rz > HALF_PI_Q30) begin
        iz = rz - PI_Q30;
        ineg = 1'b1;
      end else if (rz < -HALF_PI_Q30) begin
        iz = rz + PI_Q30;
        ineg = 1'b1;
      end
    end
  end

  // One micro-rotation.
  always_comb begin
    xs = x >>> cnt;
    ys = y >>> cnt;
    a  = atan_q30(ATAN_IDX_W'(cnt));
    cw = (mode_r == COR_VEC) ? (y > 0) : (z < 0);
    if (cw) begin
      x_next = x + ys;
      y_next = y - xs;
      z_next = z + a;
    end else begin
      x_next = x - ys;
      y_next = y + xs;
      z_next = z - a;
    end
  end

  // Gain correction of the magnitude.
  always_comb begin
    xc = x[XY_W-1] ? '0 : XY_W'(x);
    mprod = 66'(xc) * 66'(MAG_GAIN_Q18) + (66'd1 << 29);
  end

  // Control of the iteration count.
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      fin  <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= fin;
      if (start) begin
        busy <= 1'b1;
        fin  <= 1'b0;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + 1'b1;
        if (cnt == CW'(STEPS - 1)) begin
          busy <= 1'b0;
          fin  <= 1'b1;
        end
      end else begin
        fin <= 1'b0;
      end
    end
  end

  // Working vector and results.
  always_ff @(posedge clk) begin
    if (start) begin
      x      <= ix;
      y      <= iy;
      z      <= iz;
      mode_r <= mode;
      neg    <= ineg;
      zero   <= (vec_x == 0) && (vec_y == 0);
    end else if (busy) begin
      x <= x_next;
      y <= y_next;
      z <= z_next;
    end
    if (fin) begin
      res_ang <= zero ? '0 : ANG_W'(rnd_shift(66'(z), 14));
      res_mag <= zero ? '0 : MAG_W'(mprod >> 30);
      res_cos <= neg ? TRIG_W'(-x) : TRIG_W'(x);
      res_sin <= neg ? TRIG_W'(-y) : TRIG_W'(y);
    end
  end

`ifndef ASSERT_OFF
  a_done_idle: assert property (@(posedge clk) disable iff (rst) done |-> !busy)
    else $error("CORDIC result flagged while still iterating");
  a_fin_done: assert property (@(posedge clk) disable iff (rst) fin |=> done)
    else $error("CORDIC finish not followed by done");
  a_start_idle: assert property (@(posedge clk) disable iff (rst) start |-> !busy && !fin)
    else $error("CORDIC started while busy");
`endif

endmodule

/* rtl/uwrc_seq.sv */
// ---------------------------------------------------------------------------
// uwrc_seq: step sequencer
// Runs the three CORDIC passes and the control and integration steps of one
// request, then waits for the output register to be free.
// ---------------------------------------------------------------------------
module uwrc_seq
  import uwrc_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  seq_stat_t stat,
  output seq_ctrl_t ctrl
);

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Next state.
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE:     if (stat.in_valid) state_next = ST_TGT_GO;
      ST_TGT_GO:   state_next = ST_TGT_WAIT;
      ST_TGT_WAIT: if (stat.cor_done) state_next = ST_REP_GO;
      ST_REP_GO:   state_next = ST_REP_WAIT;
      ST_REP_WAIT: if (stat.cor_done) state_next = ST_CTRL1;
      ST_CTRL1:    state_next = ST_CTRL2;
      ST_CTRL2:    state_next = ST_CTRL3;
      ST_CTRL3:    state_next = ST_ROT_GO;
      ST_ROT_GO:   state_next = ST_ROT_WAIT;
      ST_ROT_WAIT: if (stat.cor_done) state_next = ST_INT;
      ST_INT:      state_next = ST_OUT;
      ST_OUT:      if (stat.out_free) state_next = ST_IDLE;
      default:     state_next = ST_IDLE;
    endcase
  end

  // Control outputs.
  always_comb begin
    ctrl = '0;
    ctrl.cor_mode = COR_VEC;
    ctrl.cor_src  = SRC_TGT;
    unique case (state)
      ST_IDLE:     ctrl.ready = 1'b1;
      ST_TGT_GO:   ctrl.cor_start = 1'b1;
      ST_TGT_WAIT: ctrl.cap_tgt = stat.cor_done;
      ST_REP_GO: begin
        ctrl.cor_start = 1'b1;
        ctrl.cor_src   = SRC_REP;
      end
      ST_REP_WAIT: ctrl.cap_rep = stat.cor_done;
      ST_CTRL1:    ctrl.ctrl1 = 1'b1;
      ST_CTRL2:    ctrl.ctrl2 = 1'b1;
      ST_CTRL3:    ctrl.ctrl3 = 1'b1;
      ST_ROT_GO: begin
        ctrl.cor_start = 1'b1;
        ctrl.cor_mode  = COR_ROT;
      end
      ST_ROT_WAIT: ctrl.cap_rot = stat.cor_done;
      ST_INT:      ctrl.integ = 1'b1;
      ST_OUT:      ctrl.out_load = stat.out_free;
      default:     ctrl.ready = 1'b0;
    endcase
  end

endmodule

/* rtl/unicycle_waypoint_rollout_controller.sv */
// ---------------------------------------------------------------------------
// unicycle_waypoint_rollout_controller: unicycle rollout step controller
// Steers toward one waypoint per request, outputs speed and turn rate and
// integrates the pose.
// ---------------------------------------------------------------------------
// The single shared CORDIC unit runs three passes per request: atan2 and
// distance to the waypoint, angle and strength of the held repulsion, and
// cosine and sine of the heading. The input is not ready while a request is
// in work; a finished result waits in the output register and a new request
// is taken meanwhile. A request with the start flag in tuser loads pose and
// repulsion before its step. There is no clearing pass.
module unicycle_waypoint_rollout_controller
  import uwrc_pkg::*;
#(
  parameter int CORDIC_STEPS = 16
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         cfg_we,
  input  logic         cfg_index,
  input  logic [19:0]  cfg_data,
  input  logic         s_tvalid,
  output logic         s_tready,
  // start_x, start_y, start_heading, rep_x, rep_y, ref_x, ref_y
  input  logic [215:0] s_tdata,
  // start_req
  input  logic         s_tuser,
  output logic         m_tvalid,
  input  logic         m_tready,
  // speed, turn_rate
  output logic [39:0]  m_tdata
);

  seq_ctrl_t ctrl;
  seq_stat_t stat;

  logic [16:0] time_step;
  logic [19:0] speed_limit;

  logic signed [31:0] pose_x, pose_y, rep_hold_x, rep_hold_y;
  logic signed [19:0] pose_heading, initial_heading;
  logic signed [31:0] ref_x_r, ref_y_r;

  logic                     cor_done;
  logic signed [ANG_W-1:0]  cor_ang;
  logic [MAG_W-1:0]         cor_mag;
  logic signed [TRIG_W-1:0] cor_cos, cor_sin;
  logic signed [32:0]       dx, dy, vec_x, vec_y;

  logic signed [19:0]  tgt, rep_ang, err, avoid;
  logic [34:0]         tgt_mag, rep_str;
  logic [19:0]         v0, v1, v_fin;
  logic                rep_on, err_big;
  logic [16:0]         fac;
  logic [30:0]         strc;
  logic signed [16:0]  om0, om_fin;
  logic signed [55:0]  bias_prod;
  logic signed [TRIG_W-1:0] cos_r, sin_r;
  logic signed [21:0]  tx, ty;
  logic signed [18:0]  hturn;

  logic signed [17:0]  ts_s;
  logic [35:0]         two_mag;
  logic signed [21:0]  err3;
  logic signed [65:0]  bias_rnd;
  logic signed [16:0]  bias;
  logic signed [18:0]  om1;
  logic [19:0]         v2;
  logic signed [65:0]  stx, sty;
  logic signed [33:0]  px_sum, py_sum;
  logic signed [31:0]  px_next, py_next;
  logic signed [19:0]  heading_next;

  assign stat.in_valid = s_tvalid;
  assign stat.cor_done = cor_done;
  assign stat.out_free = !m_tvalid || m_tready;
  assign s_tready = ctrl.ready;
  assign ts_s = $signed({1'b0, time_step});

  uwrc_seq u_seq (
    .clk  (clk),
    .rst  (rst),
    .stat (stat),
    .ctrl (ctrl)
  );

  // Vector source for the CORDIC: waypoint offset or held repulsion.
  assign dx = 33'(ref_x_r) - 33'(pose_x);
  assign dy = 33'(ref_y_r) - 33'(pose_y);
  assign vec_x = (ctrl.cor_src == SRC_REP) ? 33'(rep_hold_x) : dx;
  assign vec_y = (ctrl.cor_src == SRC_REP) ? 33'(rep_hold_y) : dy;

  uwrc_cordic #(
    .STEPS (CORDIC_STEPS)
  ) u_cordic (
    .clk     (clk),
    .rst     (rst),
    .start   (ctrl.cor_start),
    .mode    (ctrl.cor_mode),
    .vec_x   (vec_x),
    .vec_y   (vec_y),
    .rot_ang (pose_heading),
    .done    (cor_done),
    .res_ang (cor_ang),
    .res_mag (cor_mag),
    .res_cos (cor_cos),
    .res_sin (cor_sin)
  );

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      time_step   <= 17'd6554;
      speed_limit <= 20'd65536;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_TIME_STEP:   time_step   <= cfg_data[16:0];
        REG_SPEED_LIMIT: speed_limit <= cfg_data;
        default:         time_step   <= time_step;
      endcase
    end
  end

  // Control law terms.
  always_comb begin
    two_mag = {1'b0, tgt_mag} << 1;
    err3 = 22'(err) * 22'sd3;
    bias_rnd = rnd_shift(66'(bias_prod), 16);
    if (bias_rnd > BIAS_MAX) begin
      bias = 17'(BIAS_MAX);
    end else if (bias_rnd < -BIAS_MAX) begin
      bias = 17'(-BIAS_MAX);
    end else begin
      bias = bias_rnd[16:0];
    end
    om1 = 19'(om0) + (rep_on ? 19'(bias) : 19'sd0);
    v2 = err_big ? 20'((36'(v1) * 36'(SLOW_Q16) + 36'd32768) >> 16) : v1;
  end

  // Pose integration terms.
  always_comb begin
    stx = rnd_shift(66'(40'(tx) * 40'(ts_s)), 16);
    sty = rnd_shift(66'(40'(ty) * 40'(ts_s)), 16);
    px_sum = 34'(pose_x) + 34'($signed(stx[23:0]));
    py_sum = 34'(pose_y) + 34'($signed(sty[23:0]));
    if (px_sum > 34'sh07FFFFFFF) begin
      px_next = 32'sh7FFFFFFF;
    end else if (px_sum < -34'sh080000000) begin
      px_next = 32'sh80000000;
    end else begin
      px_next = px_sum[31:0];
    end
    if (py_sum > 34'sh07FFFFFFF) begin
      py_next = 32'sh7FFFFFFF;
    end else if (py_sum < -34'sh080000000) begin
      py_next = 32'sh80000000;
    end else begin
      py_next = py_sum[31:0];
    end
    heading_next = 20'(wrap_pi(24'(pose_heading) + 24'(hturn)));
  end

  // Pose and repulsion state.
  always_ff @(posedge clk) begin
    if (rst) begin
      pose_x          <= '0;
      pose_y          <= '0;
      pose_heading    <= '0;
      initial_heading <= '0;
      rep_hold_x      <= '0;
      rep_hold_y      <= '0;
    end else if (ctrl.ready && s_tvalid) begin
      if (s_tuser) begin
        pose_x          <= $signed(s_tdata[31:0]);
        pose_y          <= $signed(s_tdata[63:32]);
        pose_heading    <= 20'(wrap_pi(24'($signed(s_tdata[82:64]))));
        initial_heading <= 20'(wrap_pi(24'($signed(s_tdata[82:64]))));
        rep_hold_x      <= $signed(s_tdata[114:83]);
        rep_hold_y      <= $signed(s_tdata[146:115]);
      end
    end else if (ctrl.out_load) begin
      pose_x       <= px_next;
      pose_y       <= py_next;
      pose_heading <= heading_next;
    end
  end

  // Working registers of one step.
  always_ff @(posedge clk) begin
    if (ctrl.ready && s_tvalid) begin
      ref_x_r <= $signed(s_tdata[178:147]);
      ref_y_r <= $signed(s_tdata[210:179]);
    end
    if (ctrl.cap_tgt) begin
      tgt     <= cor_ang;
      tgt_mag <= cor_mag;
    end
    if (ctrl.cap_rep) begin
      rep_ang <= cor_ang;
      rep_str <= cor_mag;
    end
    if (ctrl.ctrl1) begin
      err    <= 20'(wrap_pi(24'(tgt) - 24'(pose_heading)));
      v0     <= (two_mag > 36'(speed_limit)) ? speed_limit : two_mag[19:0];
      avoid  <= 20'(wrap_pi(24'(rep_ang) + 24'(initial_heading) - 24'(pose_heading)));
      rep_on <= rep_str > 35'(REP_MIN);
      fac    <= (rep_str > 35'(REP_SAT)) ? 17'(FLOOR_Q17) : 17'(35'(FAC_ONE) - rep_str);
      // Beyond 2^31 the bias saturates for any non-zero angle.
      strc   <= (rep_str > 35'h07FFFFFFF) ? 31'h7FFFFFFF : rep_str[30:0];
    end
    if (ctrl.ctrl2) begin
      if (err3 > TURN_MAX) begin
        om0 <= 17'(TURN_MAX);
      end else if (err3 < -TURN_MAX) begin
        om0 <= 17'(-TURN_MAX);
      end else begin
        om0 <= err3[16:0];
      end
      bias_prod <= (56'(avoid) * 56'($signed({1'b0, strc}))) <<< 1;
      v1 <= rep_on ? 20'((37'(v0) * 37'(fac) + 37'd65536) >> 17) : v0;
      err_big <= (err > ERR_LIMIT) || (err < -ERR_LIMIT);
    end
    if (ctrl.ctrl3) begin
      if (om1 > TURN_MAX) begin
        om_fin <= 17'(TURN_MAX);
      end else if (om1 < -TURN_MAX) begin
        om_fin <= 17'(-TURN_MAX);
      end else begin
        om_fin <= om1[16:0];
      end
      v_fin <= (v2 > speed_limit) ? speed_limit : v2;
    end
    if (ctrl.cap_rot) begin
      cos_r <= cor_cos;
      sin_r <= cor_sin;
    end
    if (ctrl.integ) begin
      tx    <= 22'(rnd_shift(66'(55'($signed({1'b0, v_fin})) * 55'(cos_r)), 30));
      ty    <= 22'(rnd_shift(66'(55'($signed({1'b0, v_fin})) * 55'(sin_r)), 30));
      hturn <= 19'(rnd_shift(66'(35'(om_fin) * 35'(ts_s)), 16));
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (ctrl.out_load) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.out_load) begin
      m_tdata <= {3'b000, om_fin, v_fin};
    end
  end

`ifndef ASSERT_OFF
  a_speed_cap: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (m_tdata[19:0] <= speed_limit))
    else $error("Speed result above the speed limit");
  a_turn_cap: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (($signed(m_tdata[36:20]) <= TURN_MAX) &&
                  ($signed(m_tdata[36:20]) >= -TURN_MAX)))
    else $error("Turn rate result out of range");
  a_one_at_a_time: assert property (@(posedge clk) disable iff (rst)
    (s_tvalid && s_tready) |=> !s_tready)
    else $error("Request taken while a step is in work");
`endif

endmodule

/* tb/uwrc_checker.sv */
// ---------------------------------------------------------------------------
// uwrc_checker: scoreboard for the waypoint rollout controller
// Watches the configuration port and both streams, predicts speed and turn
// rate of every accepted request and compares them with the outputs.
// ---------------------------------------------------------------------------
module uwrc_checker
  import uwrc_pkg::*;
(
  input  logic         clk,
  input  logic         rst,
  input  logic         cfg_we,
  input  logic         cfg_index,
  input  logic [19:0]  cfg_data,
  input  logic         s_tvalid,
  input  logic         s_tready,
  input  logic [215:0] s_tdata,
  input  logic         s_tuser,
  input  logic         m_tvalid,
  input  logic         m_tready,
  input  logic [39:0]  m_tdata,
  output int           fail_count,
  output int           pending
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int STEPS = 16;
  localparam longint PI_Q30_L = 64'sd3373259426;
  localparam longint HALF_PI_L = 64'sd1686629713;

  typedef struct {
    longint speed;
    longint turn;
  } control_t;

  control_t control_queue[$];

  longint step_len, max_speed;
  longint px, py, ph, h0, rep_x, rep_y;

  function automatic longint atan_entry(int i);
    longint tab [24] = '{843314857, 497837829, 263043837, 133525159, 67021687,
      33543516, 16775851, 8388437, 4194283, 2097149, 1048576, 524288, 262144,
      131072, 65536, 32768, 16384, 8192, 4096, 2048, 1024, 512, 256, 128};
    return tab[i];
  endfunction

  // Rounded shift, half away from zero.
  function automatic longint round_shift(longint v, int s);
    longint half;
    half = 64'sd1 <<< (s - 1);
    if (v < 0) return -((-v + half) >>> s);
    return (v + half) >>> s;
  endfunction

  function automatic longint clip(longint v, longint lo, longint hi);
    return v < lo ? lo : (v > hi ? hi : v);
  endfunction

  function automatic longint wrap_angle(longint a);
    for (int k = 0; k < 4; k++) begin
      if (a > PI_Q16) a -= TWO_PI_Q16;
      else if (a < -PI_Q16) a += TWO_PI_Q16;
    end
    return a;
  endfunction

  // Angle and magnitude of a vector.
  task automatic polar(input longint vx, input longint vy, output longint ang,
                       output longint mag);
    longint x, y, z, t, xs, ys;
    z = 0;
    if (vx == 0 && vy == 0) begin
      ang = 0;
      mag = 0;
      return;
    end
    x = vx * 4096;
    y = vy * 4096;
    if (x < 0) begin
      t = x;
      if (y >= 0) begin
        x = y; y = -t; z = HALF_PI_L;
      end else begin
        x = -y; y = t; z = -HALF_PI_L;
      end
    end
    for (int i = 0; i < STEPS; i++) begin
      xs = x >>> i;
      ys = y >>> i;
      if (y > 0) begin
        x += ys; y -= xs; z += atan_entry(i);
      end else begin
        x -= ys; y += xs; z -= atan_entry(i);
      end
    end
    if (x < 0) x = 0;
    ang = round_shift(z, 14);
    mag = longint'(($unsigned(x) * 64'd159188 + (64'd1 << 29)) >> 30);
  endtask

  task automatic cos_sin(input longint h, output longint c, output longint s);
    longint z, x, y, xs, ys;
    bit flip;
    z = h * 16384;
    x = 652032874;
    y = 0;
    flip = 0;
    if (z > HALF_PI_L) begin
      z -= PI_Q30_L; flip = 1;
    end else if (z < -HALF_PI_L) begin
      z += PI_Q30_L; flip = 1;
    end
    for (int i = 0; i < STEPS; i++) begin
      xs = x >>> i;
      ys = y >>> i;
      if (z >= 0) begin
        x -= ys; y += xs; z -= atan_entry(i);
      end else begin
        x += ys; y -= xs; z += atan_entry(i);
      end
    end
    c = flip ? -x : x;
    s = flip ? -y : y;
  endtask

  // One controller step: returns the controls and advances the pose.
  task automatic predict_step(input logic [215:0] d, input logic start);
    longint tgt, tgt_mag, err, v, om, ra, st, avoid, bias, f, c, s, t;
    control_t r;
    if (start) begin
      px = longint'($signed(d[31:0]));
      py = longint'($signed(d[63:32]));
      ph = wrap_angle(longint'($signed(d[82:64])));
      h0 = ph;
      rep_x = longint'($signed(d[114:83]));
      rep_y = longint'($signed(d[146:115]));
    end
    polar(longint'($signed(d[178:147])) - px, longint'($signed(d[210:179])) - py,
          tgt, tgt_mag);
    err = wrap_angle(tgt - ph);
    v = tgt_mag * 2;
    if (v > max_speed) v = max_speed;
    om = clip(err * 3, -TURN_MAX, TURN_MAX);
    polar(rep_x, rep_y, ra, st);
    if (st > REP_MIN) begin
      avoid = wrap_angle(ra + h0 - ph);
      bias = clip(round_shift(avoid * st * 2, 16), -BIAS_MAX, BIAS_MAX);
      f = FAC_ONE - st;
      if (f < FLOOR_Q17) f = FLOOR_Q17;
      om += bias;
      v = (v * f + 65536) >>> 17;
    end
    if (err > ERR_LIMIT || err < -ERR_LIMIT) v = (v * SLOW_Q16 + 32768) >>> 16;
    v = clip(v, 0, max_speed);
    om = clip(om, -TURN_MAX, TURN_MAX);
    r.speed = v;
    r.turn = om;
    control_queue.push_back(r);
    cos_sin(ph, c, s);
    t = round_shift(v * c, 30);
    px = clip(px + round_shift(t * step_len, 16), -64'sd2147483648, 64'sd2147483647);
    t = round_shift(v * s, 30);
    py = clip(py + round_shift(t * step_len, 16), -64'sd2147483648, 64'sd2147483647);
    ph = wrap_angle(ph + round_shift(om * step_len, 16));
  endtask

  // Track configuration, predict on input requests and check outputs.
  always @(posedge clk) begin
    control_t want;
    int errs;
    errs = 0;
    if (rst) begin
      step_len <= 6554;
      max_speed <= 65536;
      px = 0; py = 0; ph = 0; h0 = 0; rep_x = 0; rep_y = 0;
      control_queue.delete();
      fail_count <= 0;
      pending <= 0;
    end else begin
      if (cfg_we) begin
        if (cfg_index == REG_TIME_STEP) step_len <= longint'(cfg_data[16:0]);
        else max_speed <= longint'(cfg_data);
      end
      if (m_tvalid && m_tready) begin
        if (control_queue.size() == 0) begin
          $error("unexpected output request %h", m_tdata);
          errs = errs + 1;
        end else begin
          want = control_queue.pop_front();
          if (m_tdata[19:0] != want.speed[19:0]) begin
            $error("speed: expected %0d, actual %0d", want.speed, m_tdata[19:0]);
            errs = errs + 1;
          end
          if ($signed(m_tdata[36:20]) != want.turn) begin
            $error("turn_rate: expected %0d, actual %0d", want.turn,
                   $signed(m_tdata[36:20]));
            errs = errs + 1;
          end
        end
      end
      if (s_tvalid && s_tready) predict_step(s_tdata, s_tuser);
      fail_count <= fail_count + errs;
      pending <= control_queue.size();
    end
  end
endmodule

/* tb/unicycle_waypoint_rollout_controller_tb.sv */
// ---------------------------------------------------------------------------
// unicycle_waypoint_rollout_controller_tb: stimulus for the rollout controller
// Drives directed and random waypoint requests under several configurations
// with random gaps on both streams; the checker judges every output.
// ---------------------------------------------------------------------------
module unicycle_waypoint_rollout_controller_tb;
  import uwrc_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CYCLE_LIMIT = 3000000;

  logic         clk;
  logic         rst;
  logic         cfg_we;
  logic         cfg_index;
  logic [19:0]  cfg_data;
  logic         s_tvalid;
  logic         s_tready;
  // start_x, start_y, start_heading, rep_x, rep_y, ref_x, ref_y
  logic [215:0] s_tdata;
  // start_req
  logic         s_tuser;
  logic         m_tvalid;
  logic         m_tready;
  // speed, turn_rate
  logic [39:0]  m_tdata;
  int           fail_count;
  int           pending;
  int           cycle_count;
  bit           hold_off;

  unicycle_waypoint_rollout_controller dut (.*);

  uwrc_checker checker_inst (.*);

  initial begin
    clk = 0;
    forever #5 clk = ~clk;
  end

  // Run watchdog.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("status: fail");
      $finish;
    end
  end

  function automatic int gap_len();
    int p;
    p = $urandom_range(0, 99);
    if (p < 55) return 0;
    if (p < 92) return $urandom_range(1, 4);
    return $urandom_range(20, 150);
  endfunction

  // Output side: random stalls, with one long hold-off on request.
  initial begin
    int g;
    m_tready = 0;
    @(negedge rst);
    forever begin
      @(posedge clk);
      if (hold_off) begin
        m_tready <= 0;
        repeat (2000) @(posedge clk);
        hold_off = 0;
      end else if ($urandom_range(0, 3) == 0) begin
        g = gap_len();
        if (g > 0) begin
          m_tready <= 0;
          repeat (g) @(posedge clk);
        end
      end
      m_tready <= 1;
    end
  end

  task automatic write_reg(logic idx, logic [19:0] val);
    cfg_we <= 1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    cfg_we <= 0;
    @(posedge clk);
  endtask

  function automatic logic [31:0] rand_pos(int mode);
    case (mode)
      0: return $urandom();
      1: return 32'($signed($urandom_range(0, 2000000)) - 1000000);
      default: return 32'($signed($urandom_range(0, 40000)) - 20000);
    endcase
  endfunction

  task automatic send(logic start, logic [31:0] sx, logic [31:0] sy, logic [18:0] hd,
                      logic [31:0] rx, logic [31:0] ry, logic [31:0] wx,
                      logic [31:0] wy);
    int g;
    s_tdata <= {5'd0, wy, wx, ry, rx, hd, sy, sx};
    s_tuser <= start;
    s_tvalid <= 1;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    g = gap_len();
    if (g > 0) begin
      s_tvalid <= 0;
      repeat (g) @(posedge clk);
    end
  endtask

  task automatic send_random(int mode);
    logic [31:0] rx, ry;
    logic [18:0] hd;
    int p;
    p = $urandom_range(0, 9);
    hd = (p == 0) ? 19'($urandom()) : 19'($signed($urandom_range(0, 411774)) - 205887);
    rx = (p < 4) ? 32'd0 : rand_pos(p % 3);
    ry = (p < 4) ? 32'd0 : rand_pos((p + 1) % 3);
    send($urandom_range(0, 7) == 0, rand_pos(mode), rand_pos(mode), hd, rx, ry,
         rand_pos(mode), rand_pos(mode));
  endtask

  task automatic drain();
    s_tvalid <= 0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (80) @(posedge clk);
  endtask

  initial begin
    logic [19:0] steps [4];
    logic [19:0] limits [4];
    rst = 1;
    cfg_we = 0;
    cfg_index = REG_TIME_STEP;
    cfg_data = 0;
    s_tvalid = 0;
    s_tdata = 0;
    s_tuser = 0;
    hold_off = 0;
    cycle_count = 0;
    repeat (8) @(posedge clk);
    rst <= 0;
    @(posedge clk);

    // Directed: reset state, zero vectors, extremes, heading wrap, repulsion.
    send(0, 0, 0, 0, 0, 0, 0, 0);
    send(0, 0, 0, 0, 0, 0, 32'h0001_0000, 0);
    send(1, 0, 0, 19'sd205887, 0, 0, 0, 0);
    send(1, 0, 0, -19'sd205887, 0, 0, 32'hFFFF_0000, 0);
    send(1, 0, 0, 19'h3FFFF, 0, 0, 0, 32'h0002_0000);
    send(1, 0, 0, 19'h40000, 32'd656, 0, 32'h0001_0000, 32'h0001_0000);
    send(1, 0, 0, 0, 32'd655, 0, 32'h0001_0000, 0);
    send(1, 0, 0, 0, 0, 32'h0001_0000, 32'h0001_0000, 0);
    send(1, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 0, 32'h8000_0000, 32'h7FFF_FFFF,
         32'h8000_0000, 32'h8000_0000);
    send(1, 32'h8000_0000, 32'h8000_0000, 19'sd100000, 32'h7FFF_FFFF, 32'h8000_0000,
         32'h7FFF_FFFF, 32'h7FFF_FFFF);
    send(1, 32'h7FFF_FF00, 0, 0, 0, 0, 32'h7FFF_FFFF, 0);
    send(0, 0, 0, 0, 0, 0, 32'h7FFF_FFFF, 0);
    send(1, 0, 0, 0, 0, 0, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    drain();

    // Phases of configuration, including the extremes.
    steps  = '{20'd65536, 20'd0, 20'h1FFFF, 20'd6554};
    limits = '{20'd655360, 20'd0, 20'hFFFFF, 20'd32768};
    for (int ph = 0; ph < 4; ph++) begin
      write_reg(REG_TIME_STEP, steps[ph]);
      write_reg(REG_SPEED_LIMIT, limits[ph]);
      if (ph == 0) hold_off = 1;
      for (int n = 0; n < 385; n++) send_random(n % 3);
      drain();
    end

    if (fail_count == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end
endmodule
